// ===== hdl/tlvc_pkg.sv =====
// Shared types and constants for the catalog entry counter.
// Holds parse phase encodings, tag codes, the file magic and the event record
// passed from the parser to the result emitter. No dependencies.
package tlvc_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_TYPE,
    PH_LEN,
    PH_BODY,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    TG_TAG,
    TG_LEN,
    TG_SKIP,
    TG_STOP
  } tag_phase_t;

  localparam logic [7:0] KIND_MESSAGES = 8'h69;

  localparam logic [7:0] TAG_NOP     = 8'h01;
  localparam logic [7:0] TAG_TRANS   = 8'h03;
  localparam logic [7:0] TAG_FIXED4  = 8'h05;
  localparam logic [7:0] TAG_LEN_6   = 8'h06;
  localparam logic [7:0] TAG_LEN_7   = 8'h07;
  localparam logic [7:0] TAG_LEN_8   = 8'h08;

  localparam logic [31:0] LEN_ALL_ONES = 32'hffff_ffff;
  localparam logic [31:0] FIXED_SKIP   = 32'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MAGIC   = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // One parsed byte may finish a messages section, end the file, or both.
  typedef struct packed {
    logic        sec_valid;
    logic [31:0] sec_count;
    logic        eof_valid;
    logic [1:0]  eof_status;
  } evt_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd0:    m = 8'h3c;
      4'd1:    m = 8'hb8;
      4'd2:    m = 8'h64;
      4'd3:    m = 8'h18;
      4'd4:    m = 8'hca;
      4'd5:    m = 8'hef;
      4'd6:    m = 8'h9c;
      4'd7:    m = 8'h95;
      4'd8:    m = 8'hcd;
      4'd9:    m = 8'h21;
      4'd10:   m = 8'h1c;
      4'd11:   m = 8'hbf;
      4'd12:   m = 8'h60;
      4'd13:   m = 8'ha1;
      4'd14:   m = 8'hbd;
      default: m = 8'hdd;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/tlvc_front.sv =====
// Byte parser: checks the magic, walks section headers and the tag stream of
// messages sections, and produces one event record per byte that ends something.
// Depends on tlvc_pkg.
module tlvc_front #(
  parameter int COUNT_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     data_byte,
  input  logic           end_of_file,
  input  logic           queue_full,
  output logic           push,
  output tlvc_pkg::evt_t evt
);

  tlvc_pkg::phase_t     phase, phase_next, phase_step;
  tlvc_pkg::tag_phase_t tag_phase, tag_phase_next;
  logic [3:0]            magic_index, magic_index_next;
  logic [7:0]            section_kind, section_kind_next;
  logic [1:0]            hbi, hbi_next;
  logic [31:0]           sbl, sbl_next;
  logic [31:0]           tag_accum, tag_accum_next;
  logic [31:0]           skip, skip_next;
  logic [COUNT_BITS-1:0] running_count, running_count_next;
  logic [1:0]            sticky, sticky_next;
  logic                  sec_fire;
  logic                  accept;

  assign accept   = in_valid & ~queue_full;
  assign in_stall = queue_full;

  always_comb begin
    logic [31:0] sbl_shift;
    logic [31:0] acc_shift;
    phase_next         = phase;
    tag_phase_next     = tag_phase;
    magic_index_next   = magic_index;
    section_kind_next  = section_kind;
    hbi_next           = hbi;
    sbl_next           = sbl;
    tag_accum_next     = tag_accum;
    skip_next          = skip;
    running_count_next = running_count;
    sticky_next        = sticky;
    sec_fire           = 1'b0;
    sbl_shift          = {sbl[23:0], data_byte};
    acc_shift          = {tag_accum[23:0], data_byte};
    if (accept) begin
      case (phase)
        tlvc_pkg::PH_MAGIC: begin
          if (data_byte != tlvc_pkg::magic_byte(magic_index)) begin
            sticky_next = tlvc_pkg::ST_MAGIC;
            phase_next  = tlvc_pkg::PH_HALT;
          end else begin
            magic_index_next = magic_index + 4'd1;
            if (magic_index == 4'd15) begin
              phase_next = tlvc_pkg::PH_TYPE;
            end
          end
        end
        tlvc_pkg::PH_TYPE: begin
          section_kind_next = data_byte;
          hbi_next          = 2'd0;
          sbl_next          = '0;
          phase_next        = tlvc_pkg::PH_LEN;
        end
        tlvc_pkg::PH_LEN: begin
          sbl_next = sbl_shift;
          if (hbi == 2'd3) begin
            running_count_next = '0;
            tag_phase_next = (section_kind == tlvc_pkg::KIND_MESSAGES) ?
                             tlvc_pkg::TG_TAG : tlvc_pkg::TG_STOP;
            if (sbl_shift == '0) begin
              sec_fire   = (section_kind == tlvc_pkg::KIND_MESSAGES);
              phase_next = tlvc_pkg::PH_TYPE;
            end else begin
              phase_next = tlvc_pkg::PH_BODY;
            end
          end else begin
            hbi_next = hbi + 2'd1;
          end
        end
        tlvc_pkg::PH_BODY: begin
          // body length is never zero here
          sbl_next = sbl - 32'd1;
          case (tag_phase)
            tlvc_pkg::TG_TAG: begin
              if (data_byte == tlvc_pkg::TAG_NOP) begin
                tag_phase_next = tlvc_pkg::TG_TAG;
              end else if (data_byte == tlvc_pkg::TAG_FIXED4) begin
                skip_next      = tlvc_pkg::FIXED_SKIP;
                tag_phase_next = tlvc_pkg::TG_SKIP;
              end else if (data_byte == tlvc_pkg::TAG_TRANS ||
                           data_byte == tlvc_pkg::TAG_LEN_6 ||
                           data_byte == tlvc_pkg::TAG_LEN_7 ||
                           data_byte == tlvc_pkg::TAG_LEN_8) begin
                if (data_byte == tlvc_pkg::TAG_TRANS && running_count != '1) begin
                  running_count_next = running_count + 1'b1;
                end
                tag_accum_next = '0;
                hbi_next       = 2'd0;
                tag_phase_next = tlvc_pkg::TG_LEN;
              end else begin
                tag_phase_next = tlvc_pkg::TG_STOP;
              end
            end
            tlvc_pkg::TG_LEN: begin
              tag_accum_next = acc_shift;
              if (hbi == 2'd3) begin
                if (acc_shift != tlvc_pkg::LEN_ALL_ONES && acc_shift != '0) begin
                  skip_next      = acc_shift;
                  tag_phase_next = tlvc_pkg::TG_SKIP;
                end else begin
                  tag_phase_next = tlvc_pkg::TG_TAG;
                end
              end else begin
                hbi_next = hbi + 2'd1;
              end
            end
            tlvc_pkg::TG_SKIP: begin
              skip_next = skip - 32'd1;
              if (skip == 32'd1) begin
                tag_phase_next = tlvc_pkg::TG_TAG;
              end
            end
            default: begin
              tag_phase_next = tag_phase;
            end
          endcase
          if (sbl == 32'd1) begin
            sec_fire   = (section_kind == tlvc_pkg::KIND_MESSAGES);
            phase_next = tlvc_pkg::PH_TYPE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
    phase_step = phase_next;
  end

  always_comb begin
    evt.sec_valid  = sec_fire;
    evt.sec_count  = 32'(running_count_next);
    evt.eof_valid  = accept & end_of_file;
    evt.eof_status = sticky_next;
    if (phase_step == tlvc_pkg::PH_MAGIC) begin
      evt.eof_status = tlvc_pkg::ST_MAGIC;
    end else if (phase_step == tlvc_pkg::PH_LEN || phase_step == tlvc_pkg::PH_BODY) begin
      evt.eof_status = tlvc_pkg::ST_OVERRUN;
    end
    push = accept & (evt.sec_valid | evt.eof_valid);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_file)) begin
      // end of file returns everything to the start-of-file state
      phase         <= tlvc_pkg::PH_MAGIC;
      tag_phase     <= tlvc_pkg::TG_TAG;
      magic_index   <= '0;
      section_kind  <= '0;
      hbi           <= '0;
      sbl           <= '0;
      tag_accum     <= '0;
      skip          <= '0;
      running_count <= '0;
      sticky        <= tlvc_pkg::ST_OK;
    end else begin
      phase         <= phase_next;
      tag_phase     <= tag_phase_next;
      magic_index   <= magic_index_next;
      section_kind  <= section_kind_next;
      hbi           <= hbi_next;
      sbl           <= sbl_next;
      tag_accum     <= tag_accum_next;
      skip          <= skip_next;
      running_count <= running_count_next;
      sticky        <= sticky_next;
    end
  end

endmodule

// ===== hdl/tlvc_queue.sv =====
// Short event queue between the parser and the result emitter.
// Depends on tlvc_pkg for the event record and the depth.
module tlvc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tlvc_pkg::evt_t push_evt,
  input  logic           pop,
  output tlvc_pkg::evt_t head,
  output logic           empty,
  output logic           full
);

  tlvc_pkg::evt_t              mem [tlvc_pkg::QUEUE_DEPTH];
  logic [tlvc_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [tlvc_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [tlvc_pkg::QPTR_BITS:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (tlvc_pkg::QPTR_BITS+1)'(tlvc_pkg::QUEUE_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/tlvc_back.sv =====
// Result emitter: turns each queued event into one or two output beats,
// section count first, end of file status second. Depends on tlvc_pkg.
module tlvc_back (
  input  logic           clk,
  input  logic           rst,
  input  tlvc_pkg::evt_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           final_result,
  output logic [31:0]    translation_count,
  output logic [1:0]     file_status
);

  logic sent;
  logic show_sec;
  logic fire;

  assign show_sec          = head.sec_valid & ~sent;
  assign out_valid         = ~empty;
  assign final_result      = ~show_sec;
  assign translation_count = show_sec ? head.sec_count : '0;
  assign file_status       = show_sec ? tlvc_pkg::ST_OK : head.eof_status;
  assign fire              = out_valid & ~out_stall;
  // hold the entry when its section beat leaves and a status beat follows
  assign pop               = fire & ~(show_sec & head.eof_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= 1'b0;
    end else if (fire) begin
      sent <= show_sec & head.eof_valid;
    end
  end

endmodule

// ===== hdl/tlv_catalog_entry_counter_top.sv =====
// Top level of the catalog entry counter; instantiates tlvc_front, tlvc_queue
// and tlvc_back. Depends on tlvc_pkg.
//
// Takes one catalog byte per cycle unless stalled: the parser keeps only counters
// and small phase registers, so each beat is classified in the cycle it arrives.
// A messages section that ends yields a beat with final_result 0 and its count;
// the byte flagged end_of_file yields a beat with final_result 1 and the status,
// after the section beat when both fall on one byte. Events wait in a four-entry
// queue, so the input stalls only when the output side has held off long enough
// to fill it. A byte that ends a section and the file yields two output beats.
module tlv_catalog_entry_counter_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        final_result,
  output logic [31:0] translation_count,
  output logic [1:0]  file_status
);

  tlvc_pkg::evt_t push_evt;
  tlvc_pkg::evt_t head;
  logic           push;
  logic           pop;
  logic           empty;
  logic           full;

  tlvc_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .end_of_file(end_of_file),
    .queue_full (full),
    .push       (push),
    .evt        (push_evt)
  );

  tlvc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_evt(push_evt),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  tlvc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .final_result     (final_result),
    .translation_count(translation_count),
    .file_status      (file_status)
  );

endmodule
